### sv/xe_pkg.sv
// shared types and character constants for the xml entity escaper
package xe_pkg;

    localparam int RUN_MAX     = 7;
    localparam int LEN_W       = $clog2(RUN_MAX + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_G     = 8'h67;

    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       text_end_out;
    } out_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] chars;
        logic [LEN_W-1:0]        len;
        logic                    text_end;
    } run_t;

endpackage

### sv/xe_front.sv
// front end: accepts a byte and builds its escaped run
module xe_front (
    input  logic          in_valid,
    output logic          in_ready,
    input  xe_pkg::in_t   in_data,
    input  logic          char_is_signed,
    input  logic          q_full,
    output logic          q_push,
    output xe_pkg::run_t  q_wdata
);
    import xe_pkg::*;

    logic [7:0]       b;
    logic             neg;
    logic [7:0]       mag;
    logic [1:0]       hund;
    logic [6:0]       rem;
    logic [14:0]      prod;
    logic [3:0]       tens;
    logic [7:0]       ones;
    logic [LEN_W-1:0] p;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign b        = in_data.in_byte;

    // decimal digits of the magnitude, tens by reciprocal multiply
    always_comb
    begin
        neg = char_is_signed && b[7];
        mag = neg ? 8'(~b + 8'd1) : b;
        if (mag >= 8'd200)
        begin
            hund = 2'd2;
            rem  = 7'(mag - 8'd200);
        end
        else if (mag >= 8'd100)
        begin
            hund = 2'd1;
            rem  = 7'(mag - 8'd100);
        end
        else
        begin
            hund = 2'd0;
            rem  = mag[6:0];
        end
        prod = 15'(rem) * 15'd205;
        tens = prod[14:11];
        ones = 8'(rem) - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};
    end

    always_comb
    begin
        q_wdata          = '0;
        q_wdata.text_end = in_data.text_end;
        p                = '0;
        unique case (b)
            CH_AMP:
            begin
                q_wdata.chars[0] = CH_AMP;
                q_wdata.chars[1] = CH_A;
                q_wdata.chars[2] = CH_M;
                q_wdata.chars[3] = CH_P;
                q_wdata.chars[4] = CH_SEMI;
                q_wdata.len      = LEN_W'(5);
            end
            CH_QUOT:
            begin
                q_wdata.chars[0] = CH_AMP;
                q_wdata.chars[1] = CH_Q;
                q_wdata.chars[2] = CH_U;
                q_wdata.chars[3] = CH_O;
                q_wdata.chars[4] = CH_T;
                q_wdata.chars[5] = CH_SEMI;
                q_wdata.len      = LEN_W'(6);
            end
            CH_APOS:
            begin
                q_wdata.chars[0] = CH_AMP;
                q_wdata.chars[1] = CH_A;
                q_wdata.chars[2] = CH_P;
                q_wdata.chars[3] = CH_O;
                q_wdata.chars[4] = CH_S;
                q_wdata.chars[5] = CH_SEMI;
                q_wdata.len      = LEN_W'(6);
            end
            CH_LT:
            begin
                q_wdata.chars[0] = CH_AMP;
                q_wdata.chars[1] = CH_L;
                q_wdata.chars[2] = CH_T;
                q_wdata.chars[3] = CH_SEMI;
                q_wdata.len      = LEN_W'(4);
            end
            CH_GT:
            begin
                q_wdata.chars[0] = CH_AMP;
                q_wdata.chars[1] = CH_G;
                q_wdata.chars[2] = CH_T;
                q_wdata.chars[3] = CH_SEMI;
                q_wdata.len      = LEN_W'(4);
            end
            default:
            begin
                if (b >= PRINT_LO && b <= PRINT_HI)
                begin
                    q_wdata.chars[0] = b;
                    q_wdata.len      = LEN_W'(1);
                end
                else
                begin
                    // numeric reference, no leading zeros
                    q_wdata.chars[0] = CH_AMP;
                    q_wdata.chars[1] = CH_HASH;
                    p = LEN_W'(2);
                    if (neg)
                    begin
                        q_wdata.chars[p] = CH_MINUS;
                        p = p + LEN_W'(1);
                    end
                    if (hund != 2'd0)
                    begin
                        q_wdata.chars[p] = CH_ZERO + 8'(hund);
                        p = p + LEN_W'(1);
                    end
                    if (hund != 2'd0 || tens != 4'd0)
                    begin
                        q_wdata.chars[p] = CH_ZERO + 8'(tens);
                        p = p + LEN_W'(1);
                    end
                    q_wdata.chars[p] = CH_ZERO + ones;
                    p = p + LEN_W'(1);
                    q_wdata.chars[p] = CH_SEMI;
                    q_wdata.len      = p + LEN_W'(1);
                end
            end
        endcase
    end

endmodule

### sv/xe_queue.sv
// short fifo of built runs between front and back
module xe_queue #(
    parameter int DEPTH = xe_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xe_pkg::run_t  wdata,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output xe_pkg::run_t  rdata
);
    import xe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign valid   = count_reg != '0;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

### sv/xe_back.sv
// back end: emits the current run one character per cycle while out_ready is high
module xe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  xe_pkg::run_t  q_rdata,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output xe_pkg::out_t  out_data
);
    import xe_pkg::*;

    localparam int POS_W = $clog2(RUN_MAX);

    run_t             run_reg, run_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             busy_reg, busy_next;
    logic             last, take, done, load;

    assign last      = pos_reg == POS_W'(run_reg.len - LEN_W'(1));
    assign out_valid = busy_reg;
    assign take      = busy_reg && out_ready;
    assign done      = take && last;
    // next run loads as the current one finishes, so single bytes stream
    assign load      = (!busy_reg || done) && q_valid;
    assign q_pop     = load;

    assign out_data.out_char     = run_reg.chars[pos_reg];
    assign out_data.run_last     = last;
    assign out_data.text_end_out = last && run_reg.text_end;

    always_comb
    begin
        run_next  = run_reg;
        pos_next  = pos_reg;
        busy_next = busy_reg;
        if (load)
        begin
            run_next  = q_rdata;
            pos_next  = '0;
            busy_next = 1'b1;
        end
        else if (done)
            busy_next = 1'b0;
        else if (take)
            pos_next = pos_reg + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

endmodule

### sv/xml_entity_escape.sv
// top level of the xml entity escaper
// Takes one text byte per request and returns its XML-escaped form one character per
// output request, with run_last on the final character of each byte's run and
// text_end_out copied onto that character. A printable byte passes through at one
// byte per cycle while out_ready holds; an escaped byte's run is four to seven
// characters long, and the back end emits one character per cycle while out_ready
// holds. A small queue of built runs (QUEUE_DEPTH deep) lets input continue while
// a run drains, and an accepted byte passes through the queue and then the back
// end's run register. char_is_signed (reset 1) makes bytes 128..255 print as negative
// decimals; write it only while the block is idle.
module xml_entity_escape #(
    parameter int QUEUE_DEPTH = xe_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  xe_pkg::in_t   in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output xe_pkg::out_t  out_data,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);
    import xe_pkg::*;

    logic char_is_signed_reg;
    logic q_full, q_push, q_pop, q_valid;
    run_t q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_is_signed_reg <= 1'b1;
        else if (cfg_we)
            char_is_signed_reg <= cfg_wdata;
    end

    xe_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .char_is_signed (char_is_signed_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    xe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    xe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_end_out |-> out_data.run_last)
        else $error("text end flagged on a character that is not the last of its run");

    a_no_early_semi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.run_last |-> out_data.out_char != CH_SEMI)
        else $error("semicolon emitted before the end of a run");

    a_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> q_valid || out_valid)
        else $error("accepted request vanished");
`endif

endmodule

### verif/xe_escape_checker.sv
// checker for the xml entity escaper: predicts each escaped run and compares characters, run_last and text_end_out
`timescale 1ns / 1ps

module xe_escape_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  xe_pkg::in_t  in_data,
    input  logic         out_valid,
    input  logic         out_ready,
    input  xe_pkg::out_t out_data,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    output int           fail_count,
    output int           pending
);
    import xe_pkg::*;

    out_t expected_chars[$];
    logic show_signed = 1'b1;
    int   mismatches  = 0;

    // append the escaped form of one request to the expected character stream
    task automatic predict_escape(input in_t req);
        logic [7:0] txt[$];
        int         mag;
        out_t       e;
        case (req.in_byte)
            CH_AMP:  txt = '{CH_AMP, CH_A, CH_M, CH_P, CH_SEMI};
            CH_QUOT: txt = '{CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI};
            CH_APOS: txt = '{CH_AMP, CH_A, CH_P, CH_O, CH_S, CH_SEMI};
            CH_LT:   txt = '{CH_AMP, CH_L, CH_T, CH_SEMI};
            CH_GT:   txt = '{CH_AMP, CH_G, CH_T, CH_SEMI};
            default:
            begin
                if (req.in_byte >= PRINT_LO && req.in_byte <= PRINT_HI)
                begin
                    txt = '{req.in_byte};
                end
                else
                begin
                    txt = '{CH_AMP, CH_HASH};
                    mag = req.in_byte;
                    if (show_signed && req.in_byte[7])
                    begin
                        txt.push_back(CH_MINUS);
                        mag = 256 - mag;
                    end
                    // decimal, no leading zeros
                    if (mag >= 100)
                        txt.push_back(CH_ZERO + 8'(mag / 100));
                    if (mag >= 10)
                        txt.push_back(CH_ZERO + 8'((mag / 10) % 10));
                    txt.push_back(CH_ZERO + 8'(mag % 10));
                    txt.push_back(CH_SEMI);
                end
            end
        endcase
        foreach (txt[k])
        begin
            e.out_char     = txt[k];
            e.run_last     = (k == txt.size() - 1);
            e.text_end_out = e.run_last ? req.text_end : 1'b0;
            expected_chars.push_back(e);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            show_signed = 1'b1;
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (cfg_we)
                show_signed = cfg_wdata;
            if (in_valid && in_ready)
                predict_escape(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character %0h with nothing pending", out_data.out_char);
                    mismatches++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_data.out_char !== want.out_char)
                    begin
                        $error("out_char: expected %0h, got %0h",
                               want.out_char, out_data.out_char);
                        mismatches++;
                    end
                    if (out_data.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, out_data.run_last);
                        mismatches++;
                    end
                    if (out_data.text_end_out !== want.text_end_out)
                    begin
                        $error("text_end_out: expected %0b, got %0b",
                               want.text_end_out, out_data.text_end_out);
                        mismatches++;
                    end
                end
            end
            pending    <= expected_chars.size();
            fail_count <= mismatches;
        end
    end

endmodule

### verif/testbench.sv
// stimulus and verdict for the xml entity escaper
`timescale 1ns / 1ps

module testbench;
    import xe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    logic quiet = 1'b0;

    xml_entity_escape dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    xe_escape_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls at random outside the quiet stretch
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(0, 99) >= 38);

    task automatic send_byte(input logic [7:0] b, input logic last_of_text);
        in_t req;
        req.in_byte  = b;
        req.text_end = last_of_text;
        while (!quiet && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_sign(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random(input int count);
        logic [7:0] b;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            quiet = (i >= 40 && i < 90);
            pick  = $urandom_range(0, 99);
            if (pick < 40)
                b = 8'($urandom_range(PRINT_LO, PRINT_HI));
            else if (pick < 60)
                case ($urandom_range(0, 4))
                    0: b = CH_AMP;
                    1: b = CH_QUOT;
                    2: b = CH_APOS;
                    3: b = CH_LT;
                    default: b = CH_GT;
                endcase
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, $urandom_range(0, 9) == 0);
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // signed decimals: the reset setting, written explicitly
        write_sign(1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h1F, 1'b1);
        send_byte(8'h20, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF6, 1'b0);
        send_byte(8'h9C, 1'b0);
        send_byte(CH_AMP, 1'b1);
        send_byte(CH_QUOT, 1'b0);
        send_byte(CH_APOS, 1'b1);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_GT, 1'b1);
        send_byte(8'h41, 1'b1);
        send_byte(8'h64, 1'b0);
        wait_idle();

        // unsigned decimals
        write_sign(1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h0A, 1'b1);
        send_random(100);
        wait_idle();

        write_sign(1'b1);
        send_random(100);
        wait_idle();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### xml_entity_escape.f
sv/xe_pkg.sv
sv/xe_front.sv
sv/xe_queue.sv
sv/xe_back.sv
sv/xml_entity_escape.sv
verif/xe_escape_checker.sv
verif/testbench.sv
